@@ hw/rtl/mbps_pkg.sv @@
// shared types and constants for the masked byte pattern scanner
package mbps_pkg;

   localparam int unsigned PATTERN_MAX_DEF = 256;
   localparam int unsigned VALUE_W = 8;
   localparam int unsigned OFFSET_W = 32;
   localparam int unsigned SEEN_W = 33;

   localparam logic [VALUE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [VALUE_W-1:0] CHAR_QMARK = 8'h3F;
   localparam logic [VALUE_W-1:0] CHAR_LOW_X = 8'h78;
   localparam logic [VALUE_W-1:0] CHAR_UP_X = 8'h58;

   typedef enum logic [1:0] {
      FUNC_TEXT = 2'd0,
      FUNC_IMAGE = 2'd1,
      FUNC_END = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_HEX = 3'd0,
      OP_WILD = 3'd1,
      OP_SPACE = 3'd2,
      OP_IMAGE = 3'd3,
      OP_END = 3'd4,
      OP_CLEAR = 3'd5
   } op_type;

   typedef struct packed {
      op_type op;
      logic [VALUE_W-1:0] data;
   } op_word_type;

endpackage

@@ hw/rtl/mbps_front.sv @@
// command intake: classifies words and queues them for the back end
module mbps_front (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_func,
   input logic [mbps_pkg::VALUE_W-1:0] req_value,
   input logic pop,
   output logic q_valid,
   output mbps_pkg::op_word_type q_word
);
   import mbps_pkg::*;

   op_word_type fifo_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, keep, do_pop;
   op_word_type cls;
   logic [3:0] hexv;
   logic is_hex;

   always_comb begin
      is_hex = 1'b0;
      hexv = 4'd0;
      if (req_value >= 8'h30 && req_value <= 8'h39) begin
         is_hex = 1'b1;
         hexv = 4'(req_value - 8'h30);
      end else if (req_value >= 8'h61 && req_value <= 8'h66) begin
         is_hex = 1'b1;
         hexv = 4'(req_value - 8'h57);
      end else if (req_value >= 8'h41 && req_value <= 8'h46) begin
         is_hex = 1'b1;
         hexv = 4'(req_value - 8'h37);
      end
   end

   always_comb begin
      keep = 1'b1;
      cls.op = OP_CLEAR;
      cls.data = req_value;
      case (func_type'(req_func))
         FUNC_TEXT: begin
            if (is_hex) begin
               cls.op = OP_HEX;
               cls.data = {4'd0, hexv};
            end else if (req_value == CHAR_SPACE) begin
               cls.op = OP_SPACE;
            end else if (req_value == CHAR_QMARK || req_value == CHAR_LOW_X
                         || req_value == CHAR_UP_X) begin
               cls.op = OP_WILD;
            end else begin
               keep = 1'b0; // other characters and high codes do nothing
            end
         end
         FUNC_IMAGE: cls.op = OP_IMAGE;
         FUNC_END: cls.op = OP_END;
         FUNC_CLEAR: cls.op = OP_CLEAR;
         default: cls.op = OP_CLEAR;
      endcase
   end

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign do_pop = pop && q_valid;
   assign q_word = fifo_ff[rp_ff];

   always_comb begin
      wp_in = push ? !wp_ff : wp_ff;
      rp_in = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= cls;
      end
   end

endmodule

@@ hw/rtl/mbps_back.sv @@
// execution side: signature parser, image window and compare sequencer
module mbps_back #(
   parameter int unsigned PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input mbps_pkg::op_word_type q_word,
   output logic pop,
   output logic rsp_valid,
   output logic rsp_found,
   output logic [mbps_pkg::OFFSET_W-1:0] rsp_match_offset,
   output logic rsp_pattern_overflow
);
   import mbps_pkg::*;

   localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
   localparam int unsigned AW = IW + 2;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   logic [8:0] pat_mem [PATTERN_MAX];
   logic [VALUE_W-1:0] win_mem [PATTERN_MAX];

   state_type state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [3:0] pnib_ff, pnib_in;
   logic pcnt_ff, pcnt_in, pwild_ff, pwild_in;
   logic ovf_ff, ovf_in;
   logic [IW-1:0] wp_ff, wp_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic hit_ff, hit_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [IW-1:0] ra_ff, ra_in;
   logic [LW-1:0] icnt_ff, icnt_in;
   logic rv_ff, rv_in, rlast_ff, rlast_in;
   logic [8:0] pdat_ff;
   logic [VALUE_W-1:0] wdat_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   logic st_en, st_care;
   logic [7:0] st_byte;
   logic pat_we;
   logic win_we;
   logic [SEEN_W-1:0] seen_new, seen_less, seen_start;
   logic [AW-1:0] ra_tmp;
   logic [IW-1:0] wp_inc, ra_inc;

   assign pop = (state_ff == S_IDLE) && q_valid;
   assign wp_inc = (wp_ff == IW'(PATTERN_MAX - 1)) ? '0 : wp_ff + 1'b1;
   assign ra_inc = (ra_ff == IW'(PATTERN_MAX - 1)) ? '0 : ra_ff + 1'b1;
   assign seen_new = (&seen_ff) ? seen_ff : seen_ff + 1'b1;
   assign seen_less = seen_new - SEEN_W'(len_ff);
   // start offset of the window under compare, count already holds the byte
   assign seen_start = seen_ff - SEEN_W'(len_ff);

   always_comb begin
      ra_tmp = AW'(wp_ff) + AW'(1) + AW'(PATTERN_MAX) - AW'(len_ff);
      if (ra_tmp >= AW'(PATTERN_MAX)) begin
         ra_tmp = ra_tmp - AW'(PATTERN_MAX);
      end
   end

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      pnib_in = pnib_ff;
      pcnt_in = pcnt_ff;
      pwild_in = pwild_ff;
      ovf_in = ovf_ff;
      wp_in = wp_ff;
      seen_in = seen_ff;
      hit_in = hit_ff;
      off_in = off_ff;
      ra_in = ra_ff;
      icnt_in = icnt_ff;
      rv_in = 1'b0;
      rlast_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_off_in = rsp_off_ff;
      rsp_ovf_in = rsp_ovf_ff;
      st_en = 1'b0;
      st_care = 1'b0;
      st_byte = 8'd0;
      win_we = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               case (q_word.op)
                  OP_HEX: begin
                     if (pcnt_ff && pwild_ff) begin
                        st_en = 1'b1;
                        pnib_in = q_word.data[3:0];
                        pcnt_in = 1'b1;
                        pwild_in = 1'b0;
                     end else if (pcnt_ff) begin
                        st_en = 1'b1;
                        st_care = 1'b1;
                        st_byte = {pnib_ff, q_word.data[3:0]};
                        pnib_in = 4'd0;
                        pcnt_in = 1'b0;
                     end else begin
                        pnib_in = q_word.data[3:0];
                        pcnt_in = 1'b1;
                        pwild_in = 1'b0;
                     end
                  end
                  OP_WILD: begin
                     if (pcnt_ff && !pwild_ff) begin
                        st_en = 1'b1;
                        st_care = 1'b1;
                        st_byte = {4'd0, pnib_ff};
                        pnib_in = 4'd0;
                        pwild_in = 1'b1;
                     end else if (pcnt_ff) begin
                        st_en = 1'b1;
                        pcnt_in = 1'b0;
                        pwild_in = 1'b0;
                     end else begin
                        pcnt_in = 1'b1;
                        pwild_in = 1'b1;
                        pnib_in = 4'd0;
                     end
                  end
                  OP_SPACE: begin
                     if (pcnt_ff) begin
                        st_en = 1'b1;
                        st_care = !pwild_ff;
                        st_byte = pwild_ff ? 8'd0 : {4'd0, pnib_ff};
                     end
                     pnib_in = 4'd0;
                     pcnt_in = 1'b0;
                     pwild_in = 1'b0;
                  end
                  OP_IMAGE: begin
                     pnib_in = 4'd0;
                     pcnt_in = 1'b0;
                     pwild_in = 1'b0;
                     win_we = 1'b1;
                     wp_in = wp_inc;
                     seen_in = seen_new;
                     if (!hit_ff && len_ff != '0 && seen_new >= SEEN_W'(len_ff)
                         && !seen_less[SEEN_W-1]) begin
                        state_in = S_SCAN;
                        ra_in = IW'(ra_tmp);
                        icnt_in = '0;
                     end
                  end
                  OP_END: begin
                     pnib_in = 4'd0;
                     pcnt_in = 1'b0;
                     pwild_in = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_found_in = (len_ff == '0) ? 1'b1 : hit_ff;
                     rsp_off_in = (len_ff != '0 && hit_ff) ? off_ff : '0;
                     rsp_ovf_in = ovf_ff;
                     seen_in = '0;
                     hit_in = 1'b0;
                     off_in = '0;
                  end
                  OP_CLEAR: begin
                     len_in = '0;
                     pnib_in = 4'd0;
                     pcnt_in = 1'b0;
                     pwild_in = 1'b0;
                     ovf_in = 1'b0;
                  end
                  default: begin
                     len_in = len_ff;
                  end
               endcase
               if (st_en) begin
                  if (len_ff < LW'(PATTERN_MAX)) begin
                     len_in = len_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
         end
         S_SCAN: begin
            if (icnt_ff < len_ff) begin
               rv_in = 1'b1;
               rlast_in = (icnt_ff == len_ff - 1'b1);
               icnt_in = icnt_ff + 1'b1;
               ra_in = ra_inc;
            end
            if (rv_ff) begin
               if (pdat_ff[8] && pdat_ff[7:0] != wdat_ff) begin
                  state_in = S_IDLE;
                  rv_in = 1'b0;
               end else if (rlast_ff) begin
                  state_in = S_IDLE;
                  rv_in = 1'b0;
                  hit_in = 1'b1;
                  off_in = seen_start[OFFSET_W-1:0];
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign pat_we = st_en && (len_ff < LW'(PATTERN_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         pnib_ff <= 4'd0;
         pcnt_ff <= 1'b0;
         pwild_ff <= 1'b0;
         ovf_ff <= 1'b0;
         wp_ff <= '0;
         seen_ff <= '0;
         hit_ff <= 1'b0;
         off_ff <= '0;
         rv_ff <= 1'b0;
         rlast_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         pnib_ff <= pnib_in;
         pcnt_ff <= pcnt_in;
         pwild_ff <= pwild_in;
         ovf_ff <= ovf_in;
         wp_ff <= wp_in;
         seen_ff <= seen_in;
         hit_ff <= hit_in;
         off_ff <= off_in;
         rv_ff <= rv_in;
         rlast_ff <= rlast_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff <= ra_in;
      icnt_ff <= icnt_in;
      rsp_found_ff <= rsp_found_in;
      rsp_off_ff <= rsp_off_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // signature store and image window, one write and one registered read each
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[len_ff[IW-1:0]] <= {st_care, st_byte};
      end
      pdat_ff <= pat_mem[icnt_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[wp_ff] <= q_word.data;
      end
      wdat_ff <= win_mem[ra_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_match_offset = rsp_off_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule

@@ hw/rtl/masked_byte_pattern_scan.sv @@
// top level of the masked byte pattern scanner
//
// channel    direction  handshake                    payload
// request    in         start / busy                 req_func, req_value
// response   out        rsp_valid (one-cycle strobe) rsp_found, rsp_match_offset,
//                                                    rsp_pattern_overflow
//
// a word is taken when start is high and busy is low; all but ignored text characters enter a two-word queue
// text, end and clear words need no window compare in the back end
// an image byte may start a window compare of up to L entries
//   (L = signature length, fewer on an early mismatch) while no hit is recorded,
//   one entry per cycle through the window and signature memory read ports
// the response strobe is registered and appears in the cycle after the end word leaves the queue
// synchronous active-high reset clears control; memories need no clearing
// busy rises only when the queue is full; the response side cannot stall
module masked_byte_pattern_scan #(
   parameter int unsigned PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_func,
   input logic [mbps_pkg::VALUE_W-1:0] req_value,
   output logic rsp_valid,
   output logic rsp_found,
   output logic [mbps_pkg::OFFSET_W-1:0] rsp_match_offset,
   output logic rsp_pattern_overflow
);
   import mbps_pkg::*;

   // queue handoff between intake and execution
   logic pop;
   logic q_valid;
   op_word_type q_word;

   mbps_front u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_value(req_value),
      .pop(pop),
      .q_valid(q_valid),
      .q_word(q_word)
   );

   // parser, window memory and compare sequencer
   mbps_back #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_word(q_word),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_match_offset(rsp_match_offset),
      .rsp_pattern_overflow(rsp_pattern_overflow)
   );

   // a miss never reports an offset
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("offset reported without a match");

   // the queue only fills up right after an accepted word
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted word");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

@@ dv/masked_byte_pattern_scan_tb.sv @@
// self-checking testbench for the masked byte pattern scanner
`timescale 1ns / 1ps

module masked_byte_pattern_scan_tb;
   import mbps_pkg::*;

   localparam int unsigned SIG_MAX = 256;
   localparam int unsigned IDLE_MAX = 14;
   localparam int unsigned STALL_LIMIT = 20000;

   typedef struct {
      logic found;
      logic [OFFSET_W-1:0] offset;
      logic overflow;
   } scan_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_func = FUNC_TEXT;
   logic [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_found;
   logic [OFFSET_W-1:0] rsp_match_offset;
   logic rsp_pattern_overflow;

   // predictor state: the signature as held entries plus the image scan state
   logic [7:0] sig_byte [SIG_MAX];
   logic sig_care [SIG_MAX];
   int unsigned sig_len;
   logic [3:0] half_nibble;
   logic half_held;
   logic half_wild;
   logic sig_dropped;
   logic [7:0] recent [SIG_MAX];
   logic [SEEN_W-1:0] image_count;
   logic hit_found;
   logic [OFFSET_W-1:0] hit_start;

   scan_report_type report_queue[$];
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   bit sender_idles = 1'b1;

   masked_byte_pattern_scan i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_match_offset(rsp_match_offset),
      .rsp_pattern_overflow(rsp_pattern_overflow)
   );

   always #2 clock = ~clock;

   // add one signature entry, or flag it when the signature is full
   function automatic void add_entry(logic [7:0] b, logic care);
      if (sig_len < SIG_MAX) begin
         sig_byte[sig_len] = b;
         sig_care[sig_len] = care;
         sig_len++;
      end else begin
         sig_dropped = 1'b1;
      end
   endfunction

   function automatic void forget_half();
      half_nibble = '0;
      half_held = 1'b0;
      half_wild = 1'b0;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic void parse_char(logic [7:0] c);
      int n;
      n = hex_digit(c);
      if (c[7]) return;
      if (n >= 0) begin
         // a lone wildcard before a digit becomes a full wildcard entry
         if (half_held && half_wild) begin
            add_entry(8'h00, 1'b0);
            forget_half();
         end
         if (half_held) begin
            add_entry({half_nibble, n[3:0]}, 1'b1);
            forget_half();
         end else begin
            half_nibble = n[3:0];
            half_held = 1'b1;
            half_wild = 1'b0;
         end
      end else if (c == CHAR_SPACE) begin
         if (half_held) begin
            if (half_wild) add_entry(8'h00, 1'b0);
            else add_entry({4'h0, half_nibble}, 1'b1);
         end
         forget_half();
      end else if (c == CHAR_QMARK || c == CHAR_LOW_X || c == CHAR_UP_X) begin
         // a lone digit before a wildcard becomes an exact byte of that value
         if (half_held && !half_wild) begin
            add_entry({4'h0, half_nibble}, 1'b1);
            forget_half();
         end
         if (half_held) begin
            add_entry(8'h00, 1'b0);
            forget_half();
         end else begin
            half_held = 1'b1;
            half_wild = 1'b1;
            half_nibble = '0;
         end
      end
   endfunction

   // shift one image byte into the window and compare the whole signature
   function automatic void scan_byte(logic [7:0] b);
      bit same;
      int unsigned base;
      for (int i = 0; i < SIG_MAX - 1; i++) recent[i] = recent[i + 1];
      recent[SIG_MAX - 1] = b;
      if (image_count != {SEEN_W{1'b1}}) image_count++;
      if (hit_found || sig_len == 0) return;
      if (image_count < sig_len) return;
      if (image_count - sig_len > 33'h0FFFFFFFF) return;
      base = SIG_MAX - sig_len;
      same = 1'b1;
      for (int j = 0; j < sig_len; j++)
         if (sig_care[j] && recent[base + j] != sig_byte[j]) same = 1'b0;
      if (same) begin
         hit_found = 1'b1;
         hit_start = OFFSET_W'(image_count - sig_len);
      end
   endfunction

   function automatic void reset_scan();
      for (int i = 0; i < SIG_MAX; i++) recent[i] = '0;
      image_count = '0;
      hit_found = 1'b0;
      hit_start = '0;
   endfunction

   // apply one accepted word to the predictor, queueing any report it causes
   function automatic void predict_word(logic [1:0] f, logic [7:0] v);
      scan_report_type r;
      case (f)
         FUNC_TEXT: parse_char(v);
         FUNC_IMAGE: begin
            forget_half();
            scan_byte(v);
         end
         FUNC_END: begin
            forget_half();
            r.found = (sig_len == 0) ? 1'b1 : hit_found;
            r.offset = (sig_len != 0 && hit_found) ? hit_start : '0;
            r.overflow = sig_dropped;
            report_queue.push_back(r);
            reset_scan();
         end
         default: begin
            sig_len = 0;
            forget_half();
            sig_dropped = 1'b0;
         end
      endcase
   endfunction

   // send one word, with a random lead-in gap; start stays high after the accept
   task automatic send_word(logic [1:0] f, logic [7:0] v);
      int unsigned gap;
      gap = sender_idles ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX)) : 0;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_func <= f;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_word(f, v);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(FUNC_TEXT, s[i]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (report_queue.size() != 0) @(posedge clock);
   endtask

   // image that embeds the current signature after lead random bytes, followed by tail random bytes
   task automatic send_image_with_hit(int unsigned lead, int unsigned tail);
      for (int i = 0; i < lead; i++) send_word(FUNC_IMAGE, 8'($urandom_range(0, 255)));
      for (int j = 0; j < sig_len; j++)
         send_word(FUNC_IMAGE, sig_care[j] ? sig_byte[j] : 8'($urandom_range(0, 255)));
      for (int i = 0; i < tail; i++) send_word(FUNC_IMAGE, 8'($urandom_range(0, 255)));
   endtask

   // random signature text, mostly well formed hex and wildcard pairs
   task automatic send_random_signature(int unsigned entries);
      string hexset;
      hexset = "0123456789abcdefABCDEF";
      for (int i = 0; i < entries; i++) begin
         case ($urandom_range(0, 9))
            0, 1: send_text($urandom_range(0, 1) ? "??" : ($urandom_range(0, 1) ? "xX" : "x?"));
            2: send_word(FUNC_TEXT, CHAR_SPACE);
            3: send_word(FUNC_TEXT, 8'($urandom_range(0, 255)));
            default: begin
               send_word(FUNC_TEXT, hexset[$urandom_range(0, 21)]);
               send_word(FUNC_TEXT, hexset[$urandom_range(0, 21)]);
            end
         endcase
      end
   endtask

   // checker: every strobe against the oldest report
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (report_queue.size() == 0) begin
            $display("%0t unexpected report found=%0b offset=%0d ovf=%0b",
                     $time, rsp_found, rsp_match_offset, rsp_pattern_overflow);
            error_count++;
         end else begin
            scan_report_type e;
            e = report_queue.pop_front();
            if (rsp_found !== e.found) begin
               $display("%0t found exp %0b got %0b", $time, e.found, rsp_found);
               error_count++;
            end
            if (rsp_match_offset !== e.offset) begin
               $display("%0t match_offset exp %0d got %0d", $time, e.offset,
                        rsp_match_offset);
               error_count++;
            end
            if (rsp_pattern_overflow !== e.overflow) begin
               $display("%0t pattern_overflow exp %0b got %0b", $time, e.overflow,
                        rsp_pattern_overflow);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with no accepted word and no report
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("masked_byte_pattern_scan: mismatch");
         $finish;
      end
   end

   // empty signature, parse corner cases, wildcard and lone digits
   task automatic test_directed();
      send_word(FUNC_END, 8'hFF);                // empty signature, empty image
      send_text("4?1 x");                        // lone digit then wildcard, space flush
      send_word(FUNC_TEXT, 8'hB1);               // high code ignored
      send_text("Ff?a");                         // lone wildcard before digit
      send_word(FUNC_IMAGE, 8'h00);
      send_word(FUNC_IMAGE, 8'h04);
      send_word(FUNC_IMAGE, 8'h77);
      send_word(FUNC_IMAGE, 8'h01);
      send_word(FUNC_IMAGE, 8'h55);
      send_word(FUNC_IMAGE, 8'hFF);
      send_word(FUNC_IMAGE, 8'h12);
      send_text("g5");                           // pending half dropped by end
      send_word(FUNC_END, 8'h00);
      send_word(FUNC_CLEAR, 8'hA5);
      send_text("00");
      send_word(FUNC_IMAGE, 8'hFF);
      send_word(FUNC_END, 8'h00);                // no hit
   endtask

   // fill the signature past capacity and check the overflow flag
   task automatic test_overflow();
      send_word(FUNC_CLEAR, 8'h00);
      for (int i = 0; i < SIG_MAX + 3; i++) send_text("??");
      send_text("a5");
      send_image_with_hit(2, 1);
      send_word(FUNC_END, 8'h00);
      send_word(FUNC_CLEAR, 8'h00);
      send_word(FUNC_END, 8'h00);
   endtask

   // random signatures and images, mostly with an embedded hit
   task automatic test_random_scans();
      int unsigned sent;
      sent = 0;
      while (sent < 1500) begin
         if ($urandom_range(0, 3) != 0) send_word(FUNC_CLEAR, 8'($urandom_range(0, 255)));
         send_random_signature($urandom_range(0, 6));
         sent += 12;
         case ($urandom_range(0, 4))
            0: for (int i = 0; i < 8; i++) begin
               // text mixed into the image
               send_word(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            1: for (int i = 0; i < 10; i++) send_word(FUNC_IMAGE, 8'($urandom_range(0, 255)));
            default: send_image_with_hit($urandom_range(0, 8), $urandom_range(0, 4));
         endcase
         sent += 14;
         send_word(FUNC_END, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 15) == 0) begin
            wait_drained();
            repeat (300) @(posedge clock);
         end
      end
   endtask

   // back-to-back words with no gaps
   task automatic test_no_gaps();
      sender_idles = 1'b0;
      send_word(FUNC_CLEAR, 8'h00);
      send_text("12x?34");
      send_image_with_hit(5, 3);
      send_word(FUNC_END, 8'h00);
      sender_idles = 1'b1;
   endtask

   initial begin
      sig_len = 0;
      sig_dropped = 1'b0;
      forget_half();
      reset_scan();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_overflow();
      test_no_gaps();
      test_random_scans();
      wait_drained();
      repeat (600) @(posedge clock);
      if (error_count == 0 && report_queue.size() == 0)
         $display("masked_byte_pattern_scan: match");
      else
         $display("masked_byte_pattern_scan: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_front.sv
hw/rtl/mbps_back.sv
hw/rtl/masked_byte_pattern_scan.sv
dv/masked_byte_pattern_scan_tb.sv
